[rtl/length_prefixed_record_deframer_assert.svh]
// Assertion macros shared by the deframer's checker.
// No dependencies; include with the bare file name.
`ifndef LENGTH_PREFIXED_RECORD_DEFRAMER_ASSERT_SVH
`define LENGTH_PREFIXED_RECORD_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define LPRD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define LPRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

[rtl/lprd_pkg.sv]
// Shared constants and types for the length-prefixed record deframer.
// No dependencies; used by the top level and its checker.
package lprd_pkg;

   localparam int BYTE_W   = 8;
   localparam int EVENT_W  = 2;
   localparam int RECLEN_W = 31;
   localparam int HDRCNT_W = 5;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 31;
   localparam int PHASE_W  = 3;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [EVENT_W-1:0]    event_type;
   typedef logic [RECLEN_W-1:0]   reclen_type;
   typedef logic [HDRCNT_W-1:0]   hdrcnt_type;
   typedef logic [CSR_IDX_W-1:0]  csr_idx_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   // Characters of interest in the stream.
   localparam byte_type CH_ZERO = 8'h30;
   localparam byte_type CH_NINE = 8'h39;
   localparam byte_type CH_LF   = 8'h0A;
   localparam byte_type CH_CR   = 8'h0D;

   // Result event codes.
   localparam event_type EV_CONSUMED = 2'd0;
   localparam event_type EV_BODY     = 2'd1;
   localparam event_type EV_DONE     = 2'd2;
   localparam event_type EV_ERROR    = 2'd3;

   // Configuration register indexes.
   localparam csr_idx_type CSR_MAX_HEADER_CHARS = 2'd0;
   localparam csr_idx_type CSR_MAX_BODY_LENGTH  = 2'd1;

   // Reset values of the configuration registers.
   localparam hdrcnt_type RST_MAX_HEADER_CHARS = 5'd18;
   localparam reclen_type RST_MAX_BODY_LENGTH  = 31'h7FFF_FFFF;

   localparam hdrcnt_type HDRCNT_SAT = 5'd31;

   // Parser phases.
   localparam logic [PHASE_W-1:0] PH_HDR_FIRST = 3'd0;
   localparam logic [PHASE_W-1:0] PH_HDR_REST  = 3'd1;
   localparam logic [PHASE_W-1:0] PH_BODY      = 3'd2;
   localparam logic [PHASE_W-1:0] PH_TERM      = 3'd3;
   localparam logic [PHASE_W-1:0] PH_TERM_LF   = 3'd4;
   localparam logic [PHASE_W-1:0] PH_ERROR     = 3'd5;

endpackage

[rtl/length_prefixed_record_deframer.sv]
// Length-prefixed record deframer: parser state, per-byte step and result register.
// Depends on lprd_pkg.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   req     | in        | req_valid/req_stall | req_in_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_event_res, rsp_out_byte, rsp_record_length
//   csr     | in        | csr_write_enable    | csr_index, csr_write_data
//
// Every accepted item produces exactly one result in the cycle after it is accepted, and a new
// item can be accepted in every cycle; the single result register sets that rate.
// The input side stalls only while a result is held and the output side stalls it.
// Reset is synchronous and active high; it returns the parser to the start of a
// header and loads the configuration registers with their defaults.
module length_prefixed_record_deframer #(
   parameter int LENGTH_BITS = 31
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  lprd_pkg::byte_type    req_in_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output lprd_pkg::event_type   rsp_event_res,
   output lprd_pkg::byte_type    rsp_out_byte,
   output lprd_pkg::reclen_type  rsp_record_length,
   input  logic                  csr_write_enable,
   input  lprd_pkg::csr_idx_type csr_index,
   input  lprd_pkg::csr_data_type csr_write_data
);
   import lprd_pkg::*;

   // The digit step needs four extra bits: (2^N - 1) * 10 + 9 fits in N + 4 bits.
   localparam int PROD_W = LENGTH_BITS + 4;

   typedef logic [LENGTH_BITS-1:0] len_type;

   // Configuration registers.
   hdrcnt_type max_hdr_ff;
   reclen_type max_body_ff;

   // Parser state.
   logic [PHASE_W-1:0] phase_ff, phase_in;
   len_type            acc_ff, acc_in;
   logic               ovf_ff, ovf_in;
   logic               ended_ff, ended_in;
   hdrcnt_type         hcnt_ff, hcnt_in;
   len_type            rem_ff, rem_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   event_type  ev_ff, ev_in;
   byte_type   ob_ff, ob_in;
   reclen_type rl_ff, rl_in;

   logic accept;
   logic is_digit;
   logic [PROD_W-1:0] prod;
   len_type rem_dec;

   // The result register can take a new item whenever it is empty or its
   // current item leaves in the same cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign is_digit = (req_in_byte >= CH_ZERO) && (req_in_byte <= CH_NINE);

   // acc * 10 + digit, built from two shifts.
   assign prod = (PROD_W'(acc_ff) << 3) + (PROD_W'(acc_ff) << 1)
               + PROD_W'(4'(req_in_byte - CH_ZERO));

   assign rem_dec = (rem_ff != '0) ? rem_ff - len_type'(1) : '0;

   always_comb begin
      phase_in = phase_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      ended_in = ended_ff;
      hcnt_in  = hcnt_ff;
      rem_in   = rem_ff;
      ev_in    = EV_CONSUMED;
      ob_in    = '0;
      rl_in    = '0;

      unique case (phase_ff) inside
         PH_HDR_FIRST: begin
            if (!is_digit || (hcnt_ff >= max_hdr_ff)) begin
               phase_in = PH_ERROR;
            end else begin
               // The accumulator is zero here, so the digit alone cannot overflow.
               acc_in   = len_type'(prod);
               hcnt_in  = (hcnt_ff < HDRCNT_SAT) ? hcnt_ff + 5'd1 : hcnt_ff;
               phase_in = PH_HDR_REST;
            end
         end
         PH_HDR_REST: begin
            if (req_in_byte == CH_LF) begin
               if (ovf_ff || (RECLEN_W'(acc_ff) > max_body_ff)) begin
                  phase_in = PH_ERROR;
               end else begin
                  rem_in   = acc_ff;
                  phase_in = (acc_ff != '0) ? PH_BODY : PH_TERM;
               end
            end else if (hcnt_ff >= max_hdr_ff) begin
               phase_in = PH_ERROR;
            end else begin
               if (!ended_ff && is_digit) begin
                  // Once overflowed the accumulator holds the limit and stops.
                  if (!ovf_ff) begin
                     if (prod[PROD_W-1 -: 4] != '0) begin
                        ovf_in = 1'b1;
                        acc_in = '1;
                     end else begin
                        acc_in = len_type'(prod);
                     end
                  end
               end else begin
                  ended_in = 1'b1;
               end
               hcnt_in = (hcnt_ff < HDRCNT_SAT) ? hcnt_ff + 5'd1 : hcnt_ff;
            end
         end
         PH_BODY: begin
            ev_in  = EV_BODY;
            ob_in  = req_in_byte;
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_TERM;
            end
         end
         PH_TERM, PH_TERM_LF: begin
            if (req_in_byte == CH_LF) begin
               ev_in    = EV_DONE;
               rl_in    = RECLEN_W'(acc_ff);
               acc_in   = '0;
               ovf_in   = 1'b0;
               ended_in = 1'b0;
               hcnt_in  = '0;
               rem_in   = '0;
               phase_in = PH_HDR_FIRST;
            end else if ((req_in_byte == CH_CR) && (phase_ff == PH_TERM)) begin
               phase_in = PH_TERM_LF;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // The error phase is sticky and masks every payload field.
      if (phase_in == PH_ERROR) begin
         ev_in = EV_ERROR;
         ob_in = '0;
         rl_in = '0;
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR_FIRST;
         acc_ff       <= '0;
         ovf_ff       <= 1'b0;
         ended_ff     <= 1'b0;
         hcnt_ff      <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            ovf_ff   <= ovf_in;
            ended_ff <= ended_in;
            hcnt_ff  <= hcnt_in;
            rem_ff   <= rem_in;
         end
      end
   end

   // Payload of the result register; it loads only with a new item.
   always_ff @(posedge clock) begin
      if (accept) begin
         ev_ff <= ev_in;
         ob_ff <= ob_in;
         rl_ff <= rl_in;
      end
   end

   // Configuration writes; an index past the register list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_hdr_ff  <= RST_MAX_HEADER_CHARS;
         max_body_ff <= RST_MAX_BODY_LENGTH;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_HEADER_CHARS: max_hdr_ff  <= hdrcnt_type'(csr_write_data[HDRCNT_W-1:0]);
            CSR_MAX_BODY_LENGTH:  max_body_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = ev_ff;
   assign rsp_out_byte      = ob_ff;
   assign rsp_record_length = rl_ff;

endmodule

[rtl/lprd_checker.sv]
// Port-level checker for the length-prefixed record deframer, bound to the top level.
// Depends on lprd_pkg and length_prefixed_record_deframer_assert.svh.
`include "length_prefixed_record_deframer_assert.svh"

module lprd_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input lprd_pkg::event_type  rsp_event_res,
   input lprd_pkg::byte_type   rsp_out_byte,
   input lprd_pkg::reclen_type rsp_record_length
);
   import lprd_pkg::*;

   // Only a body item carries a byte.
   `LPRD_ASSERT_NOW(a_byte_only_in_body, clock, reset,
      rsp_valid && (rsp_event_res != EV_BODY), rsp_out_byte == '0)

   // Only a completed record carries a length.
   `LPRD_ASSERT_NOW(a_length_only_when_done, clock, reset,
      rsp_valid && (rsp_event_res != EV_DONE), rsp_record_length == '0)

   // Once an error item has gone out, the next item shown is an error too.
   `LPRD_ASSERT_NEXT(a_error_sticky, clock, reset,
      rsp_valid && !rsp_stall && (rsp_event_res == EV_ERROR),
      !rsp_valid || (rsp_event_res == EV_ERROR))

   // A stalled result stays in place.
   `LPRD_ASSERT_NEXT(a_stalled_result_holds, clock, reset,
      rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_event_res) && $stable(rsp_out_byte)
         && $stable(rsp_record_length))

endmodule

bind length_prefixed_record_deframer lprd_checker u_lprd_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_event_res     (rsp_event_res),
   .rsp_out_byte      (rsp_out_byte),
   .rsp_record_length (rsp_record_length)
);

[test/length_prefixed_record_deframer_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for length_prefixed_record_deframer.
// It depends on lprd_pkg and the deframer RTL, and drives the block through
// directed records, random record streams with idling on both sides, and one
// final framing fault.
module length_prefixed_record_deframer_tb;
   import lprd_pkg::*;

   localparam int LENGTH_BITS = 31;
   localparam logic [63:0] LEN_LIMIT = (64'd1 << LENGTH_BITS) - 64'd1;
   localparam reclen_type LEN_MAX = 31'h7FFF_FFFF;

   // Register indexes that decode to no register; writes there must be ignored.
   localparam csr_idx_type CSR_SPARE_LO = 2'd2;
   localparam csr_idx_type CSR_SPARE_HI = 2'd3;

   // Each random phase stops once this many items have been accepted.
   localparam int PHASE_ITEMS = 170;

   // Ways to push the parser into its error state at the end of the run.
   typedef enum int {
      FAULT_BAD_FIRST,
      FAULT_LONG_HEADER,
      FAULT_OVER_LIMIT,
      FAULT_OVERFLOW,
      FAULT_BAD_TERM,
      FAULT_BAD_CRLF
   } fault_kind_type;

   typedef struct packed {
      event_type  evt;
      byte_type   data;
      reclen_type rec_len;
   } deframe_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   byte_type     req_in_byte = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   event_type    rsp_event_res;
   byte_type     rsp_out_byte;
   reclen_type   rsp_record_length;
   logic         csr_write_enable = 1'b0;
   csr_idx_type  csr_index = '0;
   csr_data_type csr_write_data = '0;

   // Idle rates in percent for the sender and the receiver.
   int unsigned  tx_idle_pct = 0;
   int unsigned  rx_idle_pct = 0;

   int unsigned  bytes_accepted = 0;
   int unsigned  fault_count = 0;

   // Results the deframer still owes, oldest first.
   deframe_result_type expected_results[$];

   // Mirror of the configuration registers.
   hdrcnt_type   cfg_max_hdr;
   reclen_type   cfg_max_len;

   // Mirror of the parser state.
   logic [PHASE_W-1:0] fsm_phase;
   logic [31:0]        len_acc;
   logic               len_ovf;
   logic               digits_done;
   hdrcnt_type         hdr_chars;
   reclen_type         body_left;

   length_prefixed_record_deframer #(
      .LENGTH_BITS(LENGTH_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_event_res(rsp_event_res),
      .rsp_out_byte(rsp_out_byte),
      .rsp_record_length(rsp_record_length),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always #2 clock = ~clock;

   // Hard stop in case the block hangs a handshake.
   initial begin
      #1_000_000;
      $display("length_prefixed_record_deframer verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // Forget everything about the record that just finished.
   function automatic void start_new_record();
      len_acc     = '0;
      len_ovf     = 1'b0;
      digits_done = 1'b0;
      hdr_chars   = '0;
      body_left   = '0;
   endfunction

   // Fold one decimal digit into the length. Once the value has run past
   // the length width it is pinned at the limit and the overflow flag stays
   // set, so the header newline will reject it.
   function automatic void add_length_digit(input byte_type b);
      logic [63:0] v;
      if (!len_ovf) begin
         v = {32'd0, len_acc} * 64'd10 + {56'd0, b - CH_ZERO};
         if (v > LEN_LIMIT) begin
            len_ovf = 1'b1;
            len_acc = LEN_LIMIT[31:0];
         end else begin
            len_acc = v[31:0];
         end
      end
   endfunction

   // Advance the mirrored parser by one stream byte and return the result
   // that the block must give for it.
   function automatic deframe_result_type deframe_byte(input byte_type b);
      deframe_result_type r;
      logic               is_dig;
      r      = '0;
      r.evt  = EV_CONSUMED;
      is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
      case (fsm_phase) inside
         PH_HDR_FIRST: begin
            if (!is_dig || hdr_chars >= cfg_max_hdr) begin
               fsm_phase = PH_ERROR;
            end else begin
               add_length_digit(b);
               if (hdr_chars != HDRCNT_SAT) hdr_chars++;
               fsm_phase = PH_HDR_REST;
            end
         end
         PH_HDR_REST: begin
            if (b == CH_LF) begin
               if (len_ovf || len_acc > {1'b0, cfg_max_len}) begin
                  fsm_phase = PH_ERROR;
               end else begin
                  body_left = len_acc[RECLEN_W-1:0];
                  fsm_phase = (body_left != '0) ? PH_BODY : PH_TERM;
               end
            end else if (hdr_chars >= cfg_max_hdr) begin
               fsm_phase = PH_ERROR;
            end else begin
               // Only the leading run of digits counts; the rest of the
               // header line is skipped.
               if (!digits_done && is_dig) add_length_digit(b);
               else digits_done = 1'b1;
               if (hdr_chars != HDRCNT_SAT) hdr_chars++;
            end
         end
         PH_BODY: begin
            r.evt  = EV_BODY;
            r.data = b;
            if (body_left != '0) body_left--;
            if (body_left == '0) fsm_phase = PH_TERM;
         end
         PH_TERM, PH_TERM_LF: begin
            if (b == CH_LF) begin
               r.evt     = EV_DONE;
               r.rec_len = len_acc[RECLEN_W-1:0];
               start_new_record();
               fsm_phase = PH_HDR_FIRST;
            end else if (b == CH_CR && fsm_phase == PH_TERM) begin
               fsm_phase = PH_TERM_LF;
            end else begin
               fsm_phase = PH_ERROR;
            end
         end
         default: fsm_phase = PH_ERROR;
      endcase
      // The error state swallows everything and blanks the payload.
      if (fsm_phase == PH_ERROR) r = '{evt: EV_ERROR, data: '0, rec_len: '0};
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Offer one byte, with random idle cycles first, and hold it until the
   // block takes it. Valid stays high afterwards so back-to-back items do
   // not see a gap; whoever pauses next lowers it.
   task automatic push_byte(input byte_type b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(deframe_byte(b));
      bytes_accepted++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(byte_type'(s[i]));
   endtask

   // Stop sending and let every outstanding result come back.
   task automatic wait_results_drained();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   // Register writes take effect at the write edge, so the mirror is
   // updated right there. Unused indexes leave the mirror alone.
   task automatic write_register(input csr_idx_type idx, input csr_data_type value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      if (idx == CSR_MAX_HEADER_CHARS) cfg_max_hdr = value[HDRCNT_W-1:0];
      else if (idx == CSR_MAX_BODY_LENGTH) cfg_max_len = value;
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // Pick new limits, weighted toward the extremes. The parser is always at
   // a record boundary here, so the new values apply to the next header.
   task automatic random_config();
      csr_data_type hdr_val;
      csr_data_type len_val;
      wait_results_drained();
      case ($urandom_range(3))
         0: hdr_val = csr_data_type'(HDRCNT_SAT);
         1: hdr_val = 31'd1;
         default: hdr_val = csr_data_type'($urandom_range(31, 1));
      endcase
      case ($urandom_range(3))
         0: len_val = LEN_MAX;
         1: len_val = csr_data_type'($urandom_range(8));
         2: len_val = csr_data_type'($urandom_range(60, 9));
         default: len_val = csr_data_type'($urandom);
      endcase
      // Upper bits of the header register are dropped by the block.
      hdr_val[CSR_DATA_W-1:HDRCNT_W] = (CSR_DATA_W-HDRCNT_W)'($urandom);
      write_register(CSR_MAX_HEADER_CHARS, hdr_val);
      write_register(CSR_MAX_BODY_LENGTH, len_val);
      if ($urandom_range(3) == 0)
         write_register($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                        csr_data_type'($urandom));
   endtask

   // One well-formed record that fits the current limits: optional leading
   // zeros, the length, optional junk after the digits, random body bytes,
   // and either terminator.
   task automatic send_random_record();
      int unsigned len;
      int unsigned budget;
      int unsigned extra;
      int unsigned zeros;
      string       num;
      byte_type    b;
      len = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(6);
      if (len > cfg_max_len) len = cfg_max_len;
      if (cfg_max_hdr < 2 && len > 9) len = 9;
      num    = $sformatf("%0d", len);
      budget = cfg_max_hdr - num.len();
      case ($urandom_range(3))
         0: extra = budget;
         1: extra = $urandom_range(budget);
         default: extra = 0;
      endcase
      zeros = $urandom_range(extra);
      repeat (zeros) push_byte(CH_ZERO);
      push_text(num);
      for (int i = 0; i < extra - zeros; i++) begin
         // The first junk byte must end the digit run; later ones may be
         // digits, which the block has to ignore.
         do b = byte_type'($urandom_range(255));
         while (b == CH_LF || (i == 0 && b >= CH_ZERO && b <= CH_NINE));
         push_byte(b);
      end
      push_byte(CH_LF);
      repeat (len) push_byte(byte_type'($urandom_range(255)));
      if ($urandom_range(1)) push_byte(CH_CR);
      push_byte(CH_LF);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Empty records go straight from the header newline to the terminator.
   task automatic test_zero_length_records();
      push_text("0");
      push_byte(CH_LF);
      push_byte(CH_LF);
   endtask

   // Digits after the first non-digit are ignored, and body bytes pass out
   // untouched even at the byte extremes.
   task automatic test_header_junk_and_body();
      push_text("2x9");
      push_byte(CH_LF);
      push_byte(8'h00);
      push_byte(8'hFF);
      push_byte(CH_CR);
      push_byte(CH_LF);
   endtask

   // Smallest limits first, with writes to the unused indexes in between
   // that must change nothing, then slightly larger ones, then the largest limits.
   task automatic test_register_extremes();
      wait_results_drained();
      write_register(CSR_MAX_HEADER_CHARS, 31'd1);
      write_register(CSR_MAX_BODY_LENGTH, 31'd0);
      write_register(CSR_SPARE_LO, LEN_MAX);
      write_register(CSR_SPARE_HI, LEN_MAX);
      push_text("0");
      push_byte(CH_LF);
      push_byte(CH_CR);
      push_byte(CH_LF);
      wait_results_drained();
      write_register(CSR_MAX_HEADER_CHARS, 31'd2);
      write_register(CSR_MAX_BODY_LENGTH, 31'd1);
      // Header exactly at its limit and a body length exactly at its limit.
      push_text("01");
      push_byte(CH_LF);
      push_byte(CH_LF);
      push_byte(CH_LF);
      wait_results_drained();
      write_register(CSR_MAX_HEADER_CHARS, csr_data_type'(HDRCNT_SAT));
      write_register(CSR_MAX_BODY_LENGTH, LEN_MAX);
   endtask

   // Streams of well-formed records with the given idle rates, new limits
   // now and then, and occasional full drains of the result pipe.
   task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
      int unsigned start;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      random_config();
      start = bytes_accepted;
      while (bytes_accepted - start < PHASE_ITEMS) begin
         if ($urandom_range(14) == 0) random_config();
         else if ($urandom_range(11) == 0) wait_results_drained();
         send_random_record();
      end
   endtask

   // The error state can only be left by reset, which happens once, so a
   // single randomly chosen fault closes the run, followed by noise that
   // must all come back as errors.
   task automatic test_sticky_error();
      fault_kind_type kind;
      int unsigned    k;
      byte_type       b;
      kind = fault_kind_type'($urandom_range(FAULT_BAD_CRLF));
      wait_results_drained();
      write_register(CSR_MAX_HEADER_CHARS, 31'd18);
      write_register(CSR_MAX_BODY_LENGTH, LEN_MAX);
      case (kind)
         FAULT_BAD_FIRST: begin
            do b = byte_type'($urandom_range(255));
            while (b >= CH_ZERO && b <= CH_NINE);
            push_byte(b);
         end
         FAULT_LONG_HEADER: begin
            // A limit of zero rejects even the first digit.
            k = $urandom_range(4);
            write_register(CSR_MAX_HEADER_CHARS, csr_data_type'(k));
            repeat (k + 1) push_text("1");
         end
         FAULT_OVER_LIMIT: begin
            k = $urandom_range(1000);
            write_register(CSR_MAX_BODY_LENGTH, csr_data_type'(k));
            push_text($sformatf("%0d", k + 1));
            push_byte(CH_LF);
         end
         FAULT_OVERFLOW: begin
            push_text($urandom_range(1) ? "2147483648" : "99999999999");
            push_byte(CH_LF);
         end
         FAULT_BAD_TERM: begin
            push_text("1");
            push_byte(CH_LF);
            push_byte(byte_type'($urandom_range(255)));
            do b = byte_type'($urandom_range(255));
            while (b == CH_LF || b == CH_CR);
            push_byte(b);
         end
         default: begin
            push_text("0");
            push_byte(CH_LF);
            push_byte(CH_CR);
            do b = byte_type'($urandom_range(255));
            while (b == CH_LF);
            push_byte(b);
         end
      endcase
      repeat (8) push_byte(byte_type'($urandom_range(255)));
   endtask

   // ---------------------------------------------------------------------
   // Receiver and checker
   // ---------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rx_idle_pct);
   end

   // Every result taken off the output is matched against the oldest
   // prediction; extra results count as failures too.
   always @(posedge clock) begin
      deframe_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected result: event %0d byte %02h length %0d",
                        rsp_event_res, rsp_out_byte, rsp_record_length);
         end else begin
            want = expected_results.pop_front();
            if (rsp_event_res !== want.evt || rsp_out_byte !== want.data ||
                rsp_record_length !== want.rec_len) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("mismatch: expected event %0d byte %02h length %0d",
                           want.evt, want.data, want.rec_len);
                  $display("          got event %0d byte %02h length %0d",
                           rsp_event_res, rsp_out_byte, rsp_record_length);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      // The mirror starts where the block does after reset.
      cfg_max_hdr = RST_MAX_HEADER_CHARS;
      cfg_max_len = RST_MAX_BODY_LENGTH;
      fsm_phase   = PH_HDR_FIRST;
      start_new_record();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_zero_length_records();
      test_header_junk_and_body();
      test_register_extremes();
      test_random_traffic(8, 87);
      test_random_traffic(87, 8);
      test_random_traffic(0, 0);
      test_sticky_error();

      // Let the last results out, then keep the input quiet to catch any
      // result the block should not have produced.
      wait_results_drained();
      repeat (4) @(posedge clock);
      if (fault_count == 0 && expected_results.size() == 0) begin
         $display("length_prefixed_record_deframer verification clean");
      end else begin
         $display("length_prefixed_record_deframer verification failed");
      end
      $finish;
   end

endmodule
